// ===== rtl/core/zgps_pkg.sv =====
`default_nettype none

package zgps_pkg;

  // Default build sizes
  localparam int MAX_ZONES_DEF  = 4;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 10;

  // Fixed field widths
  localparam int SUM_W    = 32;
  localparam int ZONE_W   = 2;   // reported zone row / column
  localparam int IDX_W    = 3;   // internal zone index, covers up to seven zones a side
  localparam int ROW_W    = 16;  // row counter, saturating
  localparam int ZPS_W    = 3;
  localparam int ZS_W     = 10;
  localparam int GAP_W    = 10;
  localparam int IMW_W    = 11;

  // Configuration channel
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONES_PER_SIDE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SIZE      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_GAP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 8'd3;

  // Register reset values
  localparam logic [ZPS_W-1:0] ZPS_RST = 3'd4;
  localparam logic [ZS_W-1:0]  ZS_RST  = 10'd64;
  localparam logic [GAP_W-1:0] GAP_RST = 10'd0;
  localparam logic [IMW_W-1:0] IMW_RST = 11'd672;

  // Controller to datapath
  typedef struct packed {
    logic             in_ready;
    logic             rd_emit;    // read port addressed by the emit index
    logic             load_zone;  // load output register with a zone sum
    logic             load_full;  // load frame sum, clear accumulators
    logic [IDX_W-1:0] emit_row;
    logic [IDX_W-1:0] emit_col;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fend_fire;  // frame-end pixel transferred this cycle
    logic out_busy;   // output register holds a result not taken this cycle
  } sts_t;

  // Unsigned add clamped at all ones
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zgps_if.sv =====
`default_nettype none

// Pixel stream
interface zgps_pixel_if #(
  parameter int PIXEL_BITS = zgps_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_end;

  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

// Result stream
interface zgps_result_if ();
  import zgps_pkg::*;
  logic              valid;
  logic              ready;
  logic [ZONE_W-1:0] zone_row;
  logic [ZONE_W-1:0] zone_col;
  logic              is_full_frame;
  logic [SUM_W-1:0]  pixel_sum;
  logic              last;

  modport source (output valid, output zone_row, output zone_col, output is_full_frame,
                  output pixel_sum, output last, input ready);
  modport sink   (input valid, input zone_row, input zone_col, input is_full_frame,
                  input pixel_sum, input last, output ready);
endinterface

// Register write channel
interface zgps_cfg_if ();
  import zgps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/zgps_ctrl.sv =====
`default_nettype none

module zgps_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [zgps_pkg::ZPS_W-1:0] n_eff_i,
  input  wire zgps_pkg::sts_t             sts_i,
  output zgps_pkg::cmd_t                  cmd_o
);
  import zgps_pkg::*;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_FLUSH   = 3'd1;
  localparam logic [2:0] ST_EMIT_RD = 3'd2;
  localparam logic [2:0] ST_EMIT_LD = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] ei_q, ei_d;
  logic [IDX_W-1:0] ej_q, ej_d;
  logic             col_last, row_last;

  assign col_last = ({1'b0, ej_q} + 4'd1) == {1'b0, n_eff_i};
  assign row_last = ({1'b0, ei_q} + 4'd1) == {1'b0, n_eff_i};

  // Sequencer: pixel run, pipeline flush, zone sweep, frame sum
  always_comb begin
    state_d         = state_q;
    ei_d            = ei_q;
    ej_d            = ej_q;
    cmd_o           = '0;
    cmd_o.emit_row  = ei_q;
    cmd_o.emit_col  = ej_q;
    unique case (state_q)
      ST_RUN: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.fend_fire) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ei_d    = '0;
        ej_d    = '0;
        state_d = (n_eff_i == '0) ? ST_FULL : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        if (!sts_i.out_busy) begin
          cmd_o.rd_emit = 1'b1;
          state_d       = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd_o.load_zone = 1'b1;
        if (col_last) begin
          ej_d = '0;
          if (row_last) begin
            state_d = ST_FULL;
          end else begin
            ei_d    = ei_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end else begin
          ej_d    = ej_q + 1'b1;
          state_d = ST_EMIT_RD;
        end
      end
      ST_FULL: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_full = 1'b1;
          state_d         = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      ei_q    <= '0;
      ej_q    <= '0;
    end else begin
      state_q <= state_d;
      ei_q    <= ei_d;
      ej_q    <= ej_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/zgps_datapath.sv =====
`default_nettype none

module zgps_datapath #(
  parameter int MAX_ZONES  = zgps_pkg::MAX_ZONES_DEF,
  parameter int MAX_WIDTH  = zgps_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = zgps_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // pixel side
  input  wire logic                        in_valid_i,
  input  wire logic [PIXEL_BITS-1:0]       pixel_i,
  input  wire logic                        frame_end_i,
  // configuration
  input  wire logic [zgps_pkg::ZPS_W-1:0]  n_eff_i,
  input  wire logic [zgps_pkg::ZS_W-1:0]   zone_size_i,
  input  wire logic [zgps_pkg::GAP_W-1:0]  column_gap_i,
  input  wire logic [zgps_pkg::IMW_W-1:0]  image_width_i,
  // control
  input  wire zgps_pkg::cmd_t              cmd_i,
  output zgps_pkg::sts_t                   sts_o,
  // result side
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output logic [zgps_pkg::ZONE_W-1:0]      zone_row_o,
  output logic [zgps_pkg::ZONE_W-1:0]      zone_col_o,
  output logic                             is_full_frame_o,
  output logic [zgps_pkg::SUM_W-1:0]       pixel_sum_o,
  output logic                             last_o
);
  import zgps_pkg::*;

  localparam int DEPTH = MAX_ZONES * MAX_ZONES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WCW   = ((CW + 1) > IMW_W) ? (CW + 1) : IMW_W;
  localparam int XCW   = ((CW > (IMW_W + IDX_W)) ? CW : (IMW_W + IDX_W)) + 1;
  localparam int YCW   = (((ZS_W + IDX_W) > ROW_W) ? (ZS_W + IDX_W) : ROW_W) + 1;

  logic                 in_fire;
  logic [CW-1:0]        x_q;
  logic [ROW_W-1:0]     y_q;
  logic [WCW-1:0]       weff;
  logic                 wrap;
  logic [SUM_W-1:0]     frame_acc_q;

  logic [IMW_W-1:0]     stride;
  logic [MAX_ZONES-1:0] col_hit, row_hit;
  logic [IDX_W-1:0]     hit_col, hit_row;
  logic                 hit;
  logic [XCW-1:0]       cstart;
  logic [YCW-1:0]       rstart;
  logic [AW-1:0]        k0, emit_addr, rd_addr;

  logic                 s1_v_q;
  logic [AW-1:0]        s1_k_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                 lw_v_q;
  logic [AW-1:0]        lw_k_q;
  logic [SUM_W-1:0]     lw_d_q;
  logic [SUM_W-1:0]     base, acc_new;

  logic [SUM_W-1:0]     mem_q [DEPTH];
  logic [DEPTH-1:0]     valid_q;
  logic [SUM_W-1:0]     rd_q;
  logic                 rdv_q;
  logic                 res_valid_q;

  assign in_fire = in_valid_i && cmd_i.in_ready;

  // Row wrap against the clamped width
  always_comb begin
    if (image_width_i == '0) begin
      weff = WCW'(1);
    end else if (WCW'(image_width_i) > WCW'(MAX_WIDTH)) begin
      weff = WCW'(MAX_WIDTH);
    end else begin
      weff = WCW'(image_width_i);
    end
  end
  assign wrap = (WCW'(x_q) + WCW'(1)) >= weff;

  // Position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (in_fire) begin
      if (frame_end_i) begin
        x_q <= '0;
        y_q <= '0;
      end else if (wrap) begin
        x_q <= '0;
        if (y_q != {ROW_W{1'b1}}) begin
          y_q <= y_q + 1'b1;
        end
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  // Whole-frame sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_acc_q <= '0;
    end else if (cmd_i.load_full) begin
      frame_acc_q <= '0;
    end else if (in_fire) begin
      frame_acc_q <= sat_add(frame_acc_q, SUM_W'(pixel_i));
    end
  end

  // Zone windows: one compare pair per zone column and per zone row
  assign stride = {1'b0, zone_size_i} + {1'b0, column_gap_i};

  always_comb begin
    cstart = '0;
    rstart = '0;
    for (int j = 0; j < MAX_ZONES; j++) begin
      cstart     = XCW'(j * stride);
      col_hit[j] = (XCW'(x_q) >= cstart) && (XCW'(x_q) < (cstart + XCW'(zone_size_i)))
                   && (ZPS_W'(j) < n_eff_i);
      rstart     = YCW'(j * zone_size_i);
      row_hit[j] = (YCW'(y_q) >= rstart) && (YCW'(y_q) < (rstart + YCW'(zone_size_i)))
                   && (ZPS_W'(j) < n_eff_i);
    end
  end

  // Windows are disjoint, so at most one bit is set in each vector
  always_comb begin
    hit_col = '0;
    hit_row = '0;
    for (int j = 0; j < MAX_ZONES; j++) begin
      if (col_hit[j]) hit_col = IDX_W'(j);
      if (row_hit[j]) hit_row = IDX_W'(j);
    end
  end

  assign hit       = (|col_hit) && (|row_hit);
  assign k0        = AW'(32'(hit_row) * MAX_ZONES + 32'(hit_col));
  assign emit_addr = AW'(32'(cmd_i.emit_row) * MAX_ZONES + 32'(cmd_i.emit_col));
  assign rd_addr   = cmd_i.rd_emit ? emit_addr : k0;

  // Second stage: read-modify-write, forwarding the previous write
  always_comb begin
    if (lw_v_q && (lw_k_q == s1_k_q)) begin
      base = lw_d_q;
    end else if (rdv_q) begin
      base = rd_q;
    end else begin
      base = '0;
    end
  end
  assign acc_new = sat_add(base, SUM_W'(s1_pix_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      lw_v_q  <= 1'b0;
      valid_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      s1_v_q <= in_fire && hit;
      lw_v_q <= s1_v_q;
      rdv_q  <= valid_q[rd_addr];
      if (cmd_i.load_full) begin
        valid_q <= '0;
      end else if (s1_v_q) begin
        valid_q[s1_k_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k_q   <= k0;
    s1_pix_q <= pixel_i;
    lw_k_q   <= s1_k_q;
    lw_d_q   <= acc_new;
  end

  // Zone accumulator store
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem_q[s1_k_q] <= acc_new;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_zone || cmd_i.load_full) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_zone) begin
      zone_row_o      <= cmd_i.emit_row[ZONE_W-1:0];
      zone_col_o      <= cmd_i.emit_col[ZONE_W-1:0];
      is_full_frame_o <= 1'b0;
      pixel_sum_o     <= rdv_q ? rd_q : '0;
      last_o          <= 1'b0;
    end else if (cmd_i.load_full) begin
      zone_row_o      <= '0;
      zone_col_o      <= '0;
      is_full_frame_o <= 1'b1;
      pixel_sum_o     <= frame_acc_q;
      last_o          <= 1'b1;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign sts_o.out_busy  = res_valid_q && !res_ready_i;
  assign sts_o.fend_fire = in_fire && frame_end_i;

endmodule

`default_nettype wire

// ===== rtl/core/zone_grid_pixel_sum_top.sv =====
`default_nettype none

// Channel  Dir  Moves                                         Transfer
// pix_if   in   pixel, frame_end                              valid && ready
// res_if   out  zone_row, zone_col, is_full_frame, pixel_sum,  valid && ready
//               last
// cfg_if   in   index, data                                   valid && ready
//
// One pixel a cycle while a frame runs; the accumulator update is a two-stage
// read-modify-write on the zone store with forwarding of the previous write.
// A frame-end pixel holds the pixel input through the flush, the zone sweep and
// the frame-sum step: the zone sweep reads the store once per result through
// its single read port. A stalled sink stretches the sweep.
// Reset clears counters, sums and zone valid bits at once; no clearing pass.

module zone_grid_pixel_sum_top #(
  parameter int MAX_ZONES  = zgps_pkg::MAX_ZONES_DEF,
  parameter int MAX_WIDTH  = zgps_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = zgps_pkg::PIXEL_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  zgps_pixel_if.sink   pix_if,
  zgps_result_if.source res_if,
  zgps_cfg_if.sink     cfg_if
);
  import zgps_pkg::*;

  logic [ZPS_W-1:0] zps_q;
  logic [ZS_W-1:0]  zs_q;
  logic [GAP_W-1:0] gap_q;
  logic [IMW_W-1:0] imw_q;
  logic [ZPS_W-1:0] n_eff;
  cmd_t             cmd;
  sts_t             sts;

  // Register file; writes beyond the list are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zps_q <= ZPS_RST;
      zs_q  <= ZS_RST;
      gap_q <= GAP_RST;
      imw_q <= IMW_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_ZONES_PER_SIDE: zps_q <= cfg_if.data[ZPS_W-1:0];
        CFG_ZONE_SIZE:      zs_q  <= cfg_if.data[ZS_W-1:0];
        CFG_COLUMN_GAP:     gap_q <= cfg_if.data[GAP_W-1:0];
        CFG_IMAGE_WIDTH:    imw_q <= cfg_if.data[IMW_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid size clamped to the built maximum
  assign n_eff = (zps_q > ZPS_W'(MAX_ZONES)) ? ZPS_W'(MAX_ZONES) : zps_q;

  zgps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_eff_i (n_eff),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  zgps_datapath #(
    .MAX_ZONES  (MAX_ZONES),
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (pix_if.valid),
    .pixel_i         (pix_if.pixel),
    .frame_end_i     (pix_if.frame_end),
    .n_eff_i         (n_eff),
    .zone_size_i     (zs_q),
    .column_gap_i    (gap_q),
    .image_width_i   (imw_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_valid_o     (res_if.valid),
    .res_ready_i     (res_if.ready),
    .zone_row_o      (res_if.zone_row),
    .zone_col_o      (res_if.zone_col),
    .is_full_frame_o (res_if.is_full_frame),
    .pixel_sum_o     (res_if.pixel_sum),
    .last_o          (res_if.last)
  );

  assign pix_if.ready = cmd.in_ready;

endmodule

`default_nettype wire
